/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

/* hw/rtl/rau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;
   localparam int OPERAND_WIDTH = 16;
   localparam int DIV_WIDTH = 64;

   localparam logic [2:0] OP_REDUCE = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_SUB    = 3'd2;
   localparam logic [2:0] OP_DIV    = 3'd3;
   localparam logic [2:0] OP_POW    = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   typedef struct packed {
      logic start;
      logic [DIV_WIDTH-1:0] dividend;
      logic [DIV_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DIV_WIDTH-1:0] quotient;
      logic [DIV_WIDTH-1:0] remainder;
   } div_rsp_type;
endpackage

/* hw/rtl/rational_arithmetic_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Rational reduce, add, subtract and divide with gcd reduction, and power.
// ----------------------------------------------------------------------------
// Input stream req_*: one transfer carries an opcode, fractions A and B and an
// exponent. Output stream rsp_*: one transfer per input with the result
// fraction and a status. One item is handled at a time; req_tready is low
// from acceptance until the result has been taken.
// The Euclid steps and the two final divides all run on the shared bit-serial
// divider, one divide at a time (up to about 25 Euclid steps for reduce, about
// 47 for add, subtract and divide). Zero over zero skips the divider, and an
// unused opcode goes straight to the output. Power does a low-half and then a
// high-half multiply for each exponent step. A new item is taken only after
// the result of the last one has been taken.
// Reset clears the sequencer; the output is empty afterwards. When the
// receiver stalls, the result waits in the output register and no new
// item is taken.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[2:0], a_num[18:3], a_den[34:19], b_num[50:35], b_den[66:51],
   // exponent[72:67], zero fill to 79
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // res_num[63:0], res_den[127:64], status[129:128], zero fill to 135
   output logic [135:0] rsp_tdata
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_EUC   = 7'b0000010,
      S_EWAIT = 7'b0000100,
      S_QNUM  = 7'b0001000,
      S_QDEN  = 7'b0010000,
      S_POW   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type    state_ff, state_in;
   logic [63:0]  x_ff, x_in, y_ff, y_in, num_ff, num_in, den_ff, den_in;
   logic [63:0]  rn_ff, rn_in, rd_ff, rd_in;
   logic [1:0]   st_ff, st_in;
   logic [5:0]   exp_ff, exp_in;
   logic         ovf_ff, ovf_in, nneg_ff, dneg_ff, nneg_in, dneg_in;
   logic         nsat_ff, dsat_ff, nsat_in, dsat_in;
   logic [31:0]  nmag_ff, dmag_ff, nmag_in, dmag_in;
   logic         phase_ff, phase_in;
   logic [63:0]  nlo_ff, nlo_in, dlo_ff, dlo_in;
   rau_pkg::div_req_type dreq;
   rau_pkg::div_rsp_type drsp;

   logic signed [31:0] an, ad, bn, bd;
   logic signed [63:0] an_bd, bn_ad, ad_bd, ad_bn;
   logic [2:0]   opcode;
   logic [63:0]  mul_n, mul_d;
   logic [95:0]  pn, pd;

   function automatic logic [63:0] sext_operand(logic [15:0] field);
      logic [63:0] raw;
      raw = 64'(field) & ((64'd1 << OPERAND_WIDTH) - 64'd1);
      if (raw[OPERAND_WIDTH-1]) raw = raw - (64'd1 << OPERAND_WIDTH);
      return raw;
   endfunction

   assign opcode = req_tdata[2:0];
   assign an = 32'(sext_operand(req_tdata[18:3]));
   assign ad = 32'(sext_operand(req_tdata[34:19]));
   assign bn = 32'(sext_operand(req_tdata[50:35]));
   assign bd = 32'(sext_operand(req_tdata[66:51]));

   assign an_bd = 64'(an) * 64'(bd);
   assign bn_ad = 64'(bn) * 64'(ad);
   assign ad_bd = 64'(ad) * 64'(bd);
   assign ad_bn = 64'(ad) * 64'(bn);

   // one 32x32 multiplier per part: low half of the accumulator, then high half
   assign mul_n = 64'(phase_ff ? rn_ff[63:32] : rn_ff[31:0]) * 64'(nmag_ff);
   assign mul_d = 64'(phase_ff ? rd_ff[63:32] : rd_ff[31:0]) * 64'(dmag_ff);
   assign pn = {mul_n, 32'd0} + {32'd0, nlo_ff};
   assign pd = {mul_d, 32'd0} + {32'd0, dlo_ff};

   rau_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_comb begin
      logic [63:0] nlim, dlim;
      nlim = nneg_ff ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
      dlim = dneg_ff ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; num_in = num_ff; den_in = den_ff;
      rn_in = rn_ff; rd_in = rd_ff; st_in = st_ff; exp_in = exp_ff;
      ovf_in = ovf_ff; nneg_in = nneg_ff; dneg_in = dneg_ff;
      nmag_in = nmag_ff; dmag_in = dmag_ff; nsat_in = nsat_ff; dsat_in = dsat_ff;
      phase_in = phase_ff; nlo_in = nlo_ff; dlo_in = dlo_ff;
      dreq = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (opcode)
                  rau_pkg::OP_REDUCE: begin num_in = 64'(an); den_in = 64'(ad); end
                  rau_pkg::OP_ADD: begin
                     num_in = an_bd + bn_ad; den_in = ad_bd;
                  end
                  rau_pkg::OP_SUB: begin
                     num_in = an_bd - bn_ad; den_in = ad_bd;
                  end
                  rau_pkg::OP_DIV: begin num_in = an_bd; den_in = ad_bn; end
                  default: begin num_in = '0; den_in = '0; end
               endcase
               case (opcode)
                  rau_pkg::OP_REDUCE, rau_pkg::OP_ADD, rau_pkg::OP_SUB,
                  rau_pkg::OP_DIV: state_in = S_EUC;
                  rau_pkg::OP_POW: begin
                     nneg_in = an[31] & req_tdata[67];
                     dneg_in = ad[31] & req_tdata[67];
                     nmag_in = an[31] ? -an : an;
                     dmag_in = ad[31] ? -ad : ad;
                     rn_in = 64'd1; rd_in = 64'd1;
                     nsat_in = 1'b0; dsat_in = 1'b0; ovf_in = 1'b0;
                     phase_in = 1'b0;
                     exp_in = req_tdata[72:67];
                     state_in = S_POW;
                  end
                  default: begin
                     rn_in = '0; rd_in = '0; st_in = rau_pkg::ST_ZERO;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_EUC: begin
            // first pass: x = den, y = num
            x_in = den_ff; y_in = num_ff;
            state_in = S_EWAIT;
            if (num_ff == 64'd0) begin
               if (den_ff == 64'd0) begin
                  rn_in = '0; rd_in = '0; st_in = rau_pkg::ST_ZERO;
                  state_in = S_OUT;
               end else begin
                  x_in = den_ff;
                  dreq.start = 1'b1; dreq.dividend = num_ff; dreq.divisor = den_ff;
                  state_in = S_QNUM;
               end
            end else begin
               dreq.start = 1'b1; dreq.dividend = den_ff; dreq.divisor = num_ff;
            end
         end
         S_EWAIT: begin
            if (drsp.done) begin
               x_in = y_ff; y_in = drsp.remainder;
               if (drsp.remainder == 64'd0) begin
                  dreq.start = 1'b1; dreq.dividend = num_ff; dreq.divisor = y_ff;
                  state_in = S_QNUM;
               end else begin
                  dreq.start = 1'b1; dreq.dividend = y_ff;
                  dreq.divisor = drsp.remainder;
               end
            end
         end
         S_QNUM: begin
            if (drsp.done) begin
               rn_in = drsp.quotient;
               dreq.start = 1'b1; dreq.dividend = den_ff; dreq.divisor = x_ff;
               state_in = S_QDEN;
            end
         end
         S_QDEN: begin
            if (drsp.done) begin
               rd_in = drsp.quotient;
               st_in = (drsp.quotient == 64'd0) ? rau_pkg::ST_ZERO : rau_pkg::ST_OK;
               state_in = S_OUT;
            end
         end
         S_POW: begin
            if (exp_ff == 6'd0) begin
               rn_in = nsat_ff ? nlim : (nneg_ff ? -rn_ff : rn_ff);
               rd_in = dsat_ff ? dlim : (dneg_ff ? -rd_ff : rd_ff);
               st_in = ((dsat_ff ? dlim : rd_ff) == 64'd0) ? rau_pkg::ST_ZERO :
                       (ovf_ff ? rau_pkg::ST_OVF : rau_pkg::ST_OK);
               state_in = S_OUT;
            end else if (!phase_ff) begin
               nlo_in = mul_n;
               dlo_in = mul_d;
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               exp_in = exp_ff - 6'd1;
               if (!nsat_ff) begin
                  if (pn > {32'd0, nlim}) begin nsat_in = 1'b1; ovf_in = 1'b1; end
                  else rn_in = pn[63:0];
               end
               if (!dsat_ff) begin
                  if (pd > {32'd0, dlim}) begin dsat_in = 1'b1; ovf_in = 1'b1; end
                  else rd_in = pd[63:0];
               end
            end
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      x_ff <= x_in; y_ff <= y_in; num_ff <= num_in; den_ff <= den_in;
      rn_ff <= rn_in; rd_ff <= rd_in; st_ff <= st_in; exp_ff <= exp_in;
      ovf_ff <= ovf_in; nneg_ff <= nneg_in; dneg_ff <= dneg_in;
      nmag_ff <= nmag_in; dmag_ff <= dmag_in; nsat_ff <= nsat_in; dsat_ff <= dsat_in;
      phase_ff <= phase_in; nlo_ff <= nlo_in; dlo_ff <= dlo_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {6'd0, st_ff, rd_ff, rn_ff};

`include "assert_macros.svh"
   `ASSERT_IMPLIES(a_ready_excl, clock, reset, req_tready, !rsp_tvalid)
   `ASSERT_NEXT(a_out_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_IMPLIES(a_div_done_ctx, clock, reset, drsp.done,
      state_ff == S_EWAIT || state_ff == S_QNUM || state_ff == S_QDEN)
endmodule

/* hw/rtl/rau_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_divider
// Signed truncating restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider (
   input  logic                clock,
   input  logic                reset,
   input  rau_pkg::div_req_type req,
   output rau_pkg::div_rsp_type rsp
);
   localparam int W = rau_pkg::DIV_WIDTH;

   logic          busy_ff, busy_in;
   logic [6:0]    count_ff, count_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic          qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic [W-1:0]  shifted;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      qneg_in  = qneg_ff;
      rneg_in  = rneg_ff;
      done_in  = 1'b0;
      shifted  = {rem_ff[W-2:0], quo_ff[W-1]};
      trial    = {1'b0, shifted} - {1'b0, dsr_ff};
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = 7'(W);
         quo_in   = req.dividend[W-1] ? -req.dividend : req.dividend;
         dsr_in   = req.divisor[W-1] ? -req.divisor : req.divisor;
         rem_in   = '0;
         qneg_in  = req.dividend[W-1] ^ req.divisor[W-1];
         rneg_in  = req.dividend[W-1];
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         count_in = count_ff - 7'd1;
         if (count_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = qneg_ff ? -quo_ff : quo_ff;
   assign rsp.remainder = rneg_ff ? -rem_ff : rem_ff;

`include "assert_macros.svh"
   `ASSERT_NEXT(a_done_one_cycle, clock, reset, done_ff, !done_ff)
   `ASSERT_IMPLIES(a_no_done_busy, clock, reset, done_ff, !busy_ff)
   `ASSERT_NEXT(a_start_busy, clock, reset, req.start, busy_ff)
endmodule

/* dv/rational_arithmetic_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test
// Streams directed and random operations through the rational unit and
// checks every result fraction and status against an in-bench predictor.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;
   localparam int NUM_RANDOM = 1330;
   localparam longint CYCLE_LIMIT = 64'd20_000_000;

   typedef struct packed {
      logic [63:0] num;
      logic [63:0] den;
      logic [1:0]  status;
   } fraction_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [79:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;

   logic [79:0]  pending_ops[$];
   fraction_type expected_fractions[$];
   int           mismatch_count;
   int           result_count;
   int           op_histogram[8];
   longint       cycle_count = 0;
   bit           quiet_window;

   rational_arithmetic_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint widen(logic [15:0] raw);
      logic [rau_pkg::OPERAND_WIDTH-1:0] v;
      v = raw[rau_pkg::OPERAND_WIDTH-1:0];
      return longint'(signed'(v));
   endfunction

   function automatic longint gcd_trunc(longint x, longint y);
      longint t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic fraction_type reduce_fraction(longint n, longint d);
      fraction_type f;
      longint g;
      g = gcd_trunc(d, n);
      if (g == 0) begin
         f.num = '0;
         f.den = '0;
         f.status = rau_pkg::ST_ZERO;
      end else begin
         f.num = n / g;
         f.den = d / g;
         f.status = (d / g == 0) ? rau_pkg::ST_ZERO : rau_pkg::ST_OK;
      end
      return f;
   endfunction

   function automatic logic [63:0] power_sat(longint base, int n, ref bit ovf);
      bit neg;
      logic [63:0] mag, lim, acc;
      neg = (base < 0) && n[0];
      mag = (base < 0) ? -base : base;
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      acc = 1;
      for (int i = 0; i < n; i++) begin
         if (mag != 0 && acc > lim / mag) begin
            ovf = 1'b1;
            return lim;
         end
         acc = acc * mag;
      end
      return neg ? -acc : acc;
   endfunction

   function automatic fraction_type predict_fraction(logic [79:0] d);
      fraction_type f;
      longint an, ad, bn, bd;
      bit ovf;
      an = widen(d[18:3]);
      ad = widen(d[34:19]);
      bn = widen(d[50:35]);
      bd = widen(d[66:51]);
      ovf = 1'b0;
      case (d[2:0])
         rau_pkg::OP_REDUCE: f = reduce_fraction(an, ad);
         rau_pkg::OP_ADD:    f = reduce_fraction(an * bd + bn * ad, ad * bd);
         rau_pkg::OP_SUB:    f = reduce_fraction(an * bd - bn * ad, ad * bd);
         rau_pkg::OP_DIV:    f = reduce_fraction(an * bd, ad * bn);
         rau_pkg::OP_POW: begin
            f.num = power_sat(an, int'(d[72:67]), ovf);
            f.den = power_sat(ad, int'(d[72:67]), ovf);
            f.status = (f.den == 0) ? rau_pkg::ST_ZERO :
                       (ovf ? rau_pkg::ST_OVF : rau_pkg::ST_OK);
         end
         default: begin
            f.num = '0;
            f.den = '0;
            f.status = rau_pkg::ST_ZERO;
         end
      endcase
      return f;
   endfunction

   function automatic logic [79:0] pack_op(logic [2:0] op, logic [15:0] an,
                                           logic [15:0] ad, logic [15:0] bn,
                                           logic [15:0] bd, logic [5:0] e);
      return {7'd0, e, bd, bn, ad, an, op};
   endfunction

   function automatic logic [15:0] rand_part();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3, 4: return 16'($signed($urandom_range(0, 40)) - 20);
         5, 6: return 16'($urandom_range(0, 2000)) * 16'($urandom_range(1, 12));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
               result_count);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_ops.size() != 0 && (quiet_window || $urandom_range(0, 99) >= 10)) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_ops[0];
            expected_fractions.push_back(predict_fraction(pending_ops[0]));
            op_histogram[pending_ops[0][2:0]]++;
            void'(pending_ops.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      fraction_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet_window || $urandom_range(0, 99) >= 10;
         if (rsp_tvalid && rsp_tready) begin
            got.num = rsp_tdata[63:0];
            got.den = rsp_tdata[127:64];
            got.status = rsp_tdata[129:128];
            if (expected_fractions.size() == 0) begin
               report_mismatch("unexpected result", got.num, '0);
            end else begin
               want = expected_fractions.pop_front();
               if (got.num != want.num) report_mismatch("res_num", got.num, want.num);
               if (got.den != want.den) report_mismatch("res_den", got.den, want.den);
               if (got.status != want.status)
                  report_mismatch("status", 64'(got.status), 64'(want.status));
            end
            result_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [2:0] op;
      mismatch_count = 0;
      result_count = 0;
      quiet_window = 1'b0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      pending_ops.push_back(pack_op(rau_pkg::OP_REDUCE, 16'd6, 16'd4, 0, 0, 0));
      pending_ops.push_back(pack_op(rau_pkg::OP_REDUCE, 16'd0, 16'd0, 0, 0, 0));
      pending_ops.push_back(pack_op(rau_pkg::OP_REDUCE, 16'd5, 16'd0, 0, 0, 0));
      pending_ops.push_back(pack_op(rau_pkg::OP_REDUCE, 16'hfffa, 16'd9, 0, 0, 0));
      pending_ops.push_back(pack_op(rau_pkg::OP_REDUCE, 16'h8000, 16'h7fff, 0, 0, 0));
      pending_ops.push_back(pack_op(rau_pkg::OP_REDUCE, 16'h8000, 16'h8000, 0, 0, 0));
      pending_ops.push_back(pack_op(rau_pkg::OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3, 0));
      pending_ops.push_back(pack_op(rau_pkg::OP_ADD, 16'h8000, 16'h8000, 16'h8000,
                                    16'h8000, 0));
      pending_ops.push_back(pack_op(rau_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'h7fff,
                                    16'h7fff, 0));
      pending_ops.push_back(pack_op(rau_pkg::OP_SUB, 16'd3, 16'd4, 16'd3, 16'd4, 0));
      pending_ops.push_back(pack_op(rau_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h7fff,
                                    16'h8000, 0));
      pending_ops.push_back(pack_op(rau_pkg::OP_DIV, 16'd2, 16'd3, 16'd0, 16'd5, 0));
      pending_ops.push_back(pack_op(rau_pkg::OP_DIV, 16'h8000, 16'h7fff, 16'h8000,
                                    16'hffff, 0));
      pending_ops.push_back(pack_op(rau_pkg::OP_POW, 16'd0, 16'd0, 0, 0, 6'd0));
      pending_ops.push_back(pack_op(rau_pkg::OP_POW, 16'd0, 16'd3, 0, 0, 6'd5));
      pending_ops.push_back(pack_op(rau_pkg::OP_POW, 16'hfffe, 16'd3, 0, 0, 6'd63));
      pending_ops.push_back(pack_op(rau_pkg::OP_POW, 16'h8000, 16'h7fff, 0, 0, 6'd63));
      pending_ops.push_back(pack_op(rau_pkg::OP_POW, 16'hfffe, 16'd1, 0, 0, 6'd63));
      pending_ops.push_back(pack_op(rau_pkg::OP_POW, 16'd2, 16'hffff, 0, 0, 6'd62));
      pending_ops.push_back(pack_op(rau_pkg::OP_POW, 16'hffff, 16'd1, 16'hffff, 16'hffff,
                                    6'd33));
      pending_ops.push_back(pack_op(3'd5, 16'd1, 16'd1, 0, 0, 0));
      pending_ops.push_back(pack_op(3'd6, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 6'h3f));
      pending_ops.push_back(pack_op(3'd7, 16'd3, 16'd7, 0, 0, 0));

      for (int i = 0; i < NUM_RANDOM; i++) begin
         op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
         pending_ops.push_back(pack_op(op, rand_part(), rand_part(), rand_part(),
                                       rand_part(), 6'($urandom)));
      end

      // a stretch with no random gaps in the requests and no result stalls in the middle of the run
      wait (pending_ops.size() < 800);
      quiet_window = 1'b1;
      wait (pending_ops.size() < 600);
      quiet_window = 1'b0;

      wait (pending_ops.size() == 0 && expected_fractions.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d results: reduce %0d add %0d sub %0d div %0d pow %0d unused %0d",
               result_count, op_histogram[0], op_histogram[1], op_histogram[2],
               op_histogram[3], op_histogram[4],
               op_histogram[5] + op_histogram[6] + op_histogram[7]);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/rau_pkg.sv
hw/rtl/rau_divider.sv
hw/rtl/rational_arithmetic_unit.sv
dv/rational_arithmetic_unit_test.sv
